/* src/tmce_pkg.sv */
// ----------------------------------------------------------------------------
// tmce_pkg
// Types and codes shared by the transactional memory commit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tmce_pkg;

    typedef enum logic [2:0] {
        K_INIT   = 3'd0,
        K_BEGIN  = 3'd1,
        K_FETCH  = 3'd2,
        K_STORE  = 3'd3,
        K_COMMIT = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNINIT   = 2'd1,
        ST_CONFLICT = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WB_RD,
        S_WB_CHK,
        S_CELL_RD,
        S_CELL_CHK,
        S_RL_RD,
        S_RL_CHK,
        S_CM_RL_RD,
        S_CM_RL_CELL,
        S_CM_RL_CHK,
        S_CM_WB_RD,
        S_CM_WB_CELL,
        S_CM_WB_WR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        vld;
        logic [31:0] ver;
        logic [31:0] val;
    } t_cell;

endpackage

`default_nettype wire

/* src/transactional_memory_commit_engine_core.sv */
// ----------------------------------------------------------------------------
// transactional_memory_commit_engine_core
// Versioned store with per-context read logs and write buffers; commit
// validates logged versions and applies buffered writes.
// ----------------------------------------------------------------------------
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------
//   input   | i_valid / o_stall  | i_kind, i_context_req, i_location, i_value
//   output  | o_valid / i_stall  | o_status, o_read_value
//
// One word is processed at a time. Buffer, log and commit entries are visited
// one at a time, and the commit steps share the one read port of the cell
// memory. After reset a clearing pass marks the first min(MEM_DEPTH, 256)
// locations invalid; o_stall is high during that pass.
// A result waits in the output register while the next word is taken.
`default_nettype none

module transactional_memory_commit_engine_core
    import tmce_pkg::*;
#(
    parameter int MEM_DEPTH = 256,
    parameter int LOG_DEPTH = 8,
    parameter int CONTEXTS  = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_kind,
    input  wire logic [1:0]         i_context_req,
    input  wire logic [7:0]         i_location,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_read_value
);

    localparam int AW    = $clog2(MEM_DEPTH);
    localparam int CLR_N = (MEM_DEPTH < 256) ? MEM_DEPTH : 256;
    localparam int NCTX  = (CONTEXTS < 4) ? CONTEXTS : 4;
    localparam int CXW   = (NCTX > 1) ? $clog2(NCTX) : 1;
    localparam int SWR   = $clog2(NCTX * LOG_DEPTH);
    localparam int SW    = (SWR > 0) ? SWR : 1;
    localparam int CNW   = $clog2(LOG_DEPTH + 1);
    localparam int EW    = AW + 32;

    logic [AW-1:0] loc_tab [256];

    for (genvar g = 0; g < 256; g++) begin : g_loc
        assign loc_tab[g] = AW'(g % MEM_DEPTH);
    end

    t_cell         cell_mem [MEM_DEPTH];
    logic [EW-1:0] rl_mem [2**SW];
    logic [EW-1:0] wb_mem [2**SW];

    t_state        r_state, n_state;
    logic [2:0]    r_kind;
    logic [1:0]    r_ctx;
    logic [AW-1:0] r_loc;
    logic [31:0]   r_val;
    logic [31:0]   r_ver, n_ver;
    logic [CNW-1:0] r_idx, n_idx;
    logic          r_ok, n_ok;
    logic [1:0]    r_status, n_status;
    logic [31:0]   r_rd, n_rd;
    logic [AW-1:0] r_clr;
    logic [CNW-1:0] r_rcnt [NCTX];
    logic [CNW-1:0] n_rcnt [NCTX];
    logic [CNW-1:0] r_wcnt [NCTX];
    logic [CNW-1:0] n_wcnt [NCTX];
    logic          r_ovld, n_ovld;
    logic [1:0]    r_ostatus, n_ostatus;
    logic [31:0]   r_ordval, n_ordval;

    t_cell         r_cell_q;
    logic [EW-1:0] r_rl_q, r_wb_q;

    logic [CXW-1:0] cx;
    logic [SW-1:0]  log_addr;
    logic [AW-1:0]  cell_ra;
    logic           cell_we;
    logic [AW-1:0]  cell_wa;
    t_cell          cell_wd;
    logic           rl_we, wb_we;
    logic [EW-1:0]  rl_wd, wb_wd;
    logic           accept;

    assign cx       = r_ctx[CXW-1:0];
    assign log_addr = SW'(r_ctx) * SW'(LOG_DEPTH) + SW'(r_idx);
    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovld;
    assign o_status = r_ostatus;
    assign o_read_value = r_ordval;

    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            cell_mem[cell_wa] <= cell_wd;
        end
        r_cell_q <= cell_mem[cell_ra];
        if (rl_we) begin
            rl_mem[log_addr] <= rl_wd;
        end
        r_rl_q <= rl_mem[log_addr];
        if (wb_we) begin
            wb_mem[log_addr] <= wb_wd;
        end
        r_wb_q <= wb_mem[log_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ovld  <= 1'b0;
            for (int c = 0; c < NCTX; c++) begin
                r_rcnt[c] <= '0;
                r_wcnt[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            r_rcnt  <= n_rcnt;
            r_wcnt  <= n_wcnt;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_ctx  <= i_context_req;
            r_loc  <= loc_tab[i_location];
            r_val  <= i_value;
        end
        r_ver     <= n_ver;
        r_idx     <= n_idx;
        r_ok      <= n_ok;
        r_status  <= n_status;
        r_rd      <= n_rd;
        r_ostatus <= n_ostatus;
        r_ordval  <= n_ordval;
    end

    always_comb begin
        n_state   = r_state;
        n_ver     = r_ver;
        n_idx     = r_idx;
        n_ok      = r_ok;
        n_status  = r_status;
        n_rd      = r_rd;
        n_rcnt    = r_rcnt;
        n_wcnt    = r_wcnt;
        n_ovld    = r_ovld && i_stall;
        n_ostatus = r_ostatus;
        n_ordval  = r_ordval;
        cell_ra   = r_loc;
        cell_we   = 1'b0;
        cell_wa   = r_loc;
        cell_wd   = '{vld: 1'b1, ver: 32'd0, val: r_val};
        rl_we     = 1'b0;
        rl_wd     = {r_loc, r_ver};
        wb_we     = 1'b0;
        wb_wd     = {r_loc, r_val};

        case (r_state)
            S_CLEAR: begin
                cell_we = 1'b1;
                cell_wa = r_clr;
                cell_wd = '{vld: 1'b0, ver: 32'd0, val: 32'd0};
                if (r_clr == AW'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_idx    = '0;
                n_ok     = 1'b1;
                n_status = ST_OK;
                n_rd     = '0;
                n_state  = S_OUT;
                if (32'(r_ctx) < CONTEXTS) begin
                    case (r_kind)
                        K_INIT:   n_state = S_CELL_RD;
                        K_BEGIN: begin
                            n_rcnt[cx] = '0;
                            n_wcnt[cx] = '0;
                        end
                        K_FETCH:  n_state = S_WB_RD;
                        K_STORE:  n_state = S_WB_RD;
                        K_COMMIT: n_state = S_CM_RL_RD;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_WB_RD: begin
                if (r_idx == r_wcnt[cx]) begin
                    if (r_kind == K_FETCH) begin
                        n_state = S_CELL_RD;
                    end else begin
                        n_state = S_OUT;
                        if (r_wcnt[cx] < CNW'(LOG_DEPTH)) begin
                            wb_we      = 1'b1;
                            n_wcnt[cx] = r_wcnt[cx] + CNW'(1);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                end else begin
                    n_state = S_WB_CHK;
                end
            end
            S_WB_CHK: begin
                if (r_wb_q[EW-1:32] == r_loc) begin
                    n_state = S_OUT;
                    if (r_kind == K_FETCH) begin
                        n_rd = r_wb_q[31:0];
                    end else begin
                        wb_we = 1'b1;
                    end
                end else begin
                    n_idx   = r_idx + CNW'(1);
                    n_state = S_WB_RD;
                end
            end
            S_CELL_RD: begin
                n_state = S_CELL_CHK;
            end
            S_CELL_CHK: begin
                if (r_kind == K_INIT) begin
                    cell_we = !r_cell_q.vld;
                    n_state = S_OUT;
                end else if (!r_cell_q.vld) begin
                    n_status = ST_UNINIT;
                    n_state  = S_OUT;
                end else begin
                    n_ver   = r_cell_q.ver;
                    n_rd    = r_cell_q.val;
                    n_idx   = '0;
                    n_state = S_RL_RD;
                end
            end
            S_RL_RD: begin
                if (r_idx == r_rcnt[cx]) begin
                    n_state = S_OUT;
                    if (r_rcnt[cx] < CNW'(LOG_DEPTH)) begin
                        rl_we      = 1'b1;
                        n_rcnt[cx] = r_rcnt[cx] + CNW'(1);
                    end else begin
                        n_status = ST_FULL;
                        n_rd     = '0;
                    end
                end else begin
                    n_state = S_RL_CHK;
                end
            end
            S_RL_CHK: begin
                if (r_rl_q[EW-1:32] == r_loc) begin
                    rl_we   = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + CNW'(1);
                    n_state = S_RL_RD;
                end
            end
            S_CM_RL_RD: begin
                if (r_idx == r_rcnt[cx]) begin
                    n_idx = '0;
                    if (r_ok) begin
                        n_state = S_CM_WB_RD;
                    end else begin
                        n_status   = ST_CONFLICT;
                        n_rcnt[cx] = '0;
                        n_wcnt[cx] = '0;
                        n_state    = S_OUT;
                    end
                end else begin
                    n_state = S_CM_RL_CELL;
                end
            end
            S_CM_RL_CELL: begin
                cell_ra = r_rl_q[EW-1:32];
                n_state = S_CM_RL_CHK;
            end
            S_CM_RL_CHK: begin
                if (!r_cell_q.vld || r_cell_q.ver != r_rl_q[31:0]) begin
                    n_ok = 1'b0;
                end
                n_idx   = r_idx + CNW'(1);
                n_state = S_CM_RL_RD;
            end
            S_CM_WB_RD: begin
                if (r_idx == r_wcnt[cx]) begin
                    n_rcnt[cx] = '0;
                    n_wcnt[cx] = '0;
                    n_state    = S_OUT;
                end else begin
                    n_state = S_CM_WB_CELL;
                end
            end
            S_CM_WB_CELL: begin
                cell_ra = r_wb_q[EW-1:32];
                n_state = S_CM_WB_WR;
            end
            S_CM_WB_WR: begin
                cell_we = 1'b1;
                cell_wa = r_wb_q[EW-1:32];
                cell_wd = '{vld: 1'b1,
                            ver: r_cell_q.vld ? r_cell_q.ver + 32'd1 : 32'd0,
                            val: r_wb_q[31:0]};
                n_idx   = r_idx + CNW'(1);
                n_state = S_CM_WB_RD;
            end
            S_OUT: begin
                if (!r_ovld || !i_stall) begin
                    n_ovld    = 1'b1;
                    n_ostatus = r_status;
                    n_ordval  = r_rd;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_rcnt[0]) <= LOG_DEPTH) && (32'(r_wcnt[0]) <= LOG_DEPTH))
        else $error("log fill count beyond depth");

    a_cell_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_we |-> (r_state == S_CLEAR || r_state == S_CELL_CHK
                     || r_state == S_CM_WB_WR))
        else $error("cell write outside a write state");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_stall) |=> (o_valid && r_state == S_IDLE))
        else $error("result not presented");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_stall)
        else $error("word accepted during clearing pass");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random operations into the transactional memory commit
// engine, predicts each status and fetched value, and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import tmce_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_DEPTH  = 256;
    localparam int LOG_DEPTH  = 8;
    localparam int CONTEXTS   = 4;
    localparam int WDOG_LIMIT = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_kind = '0;
    logic [1:0]         i_context_req = '0;
    logic [7:0]         i_location = '0;
    logic signed [31:0] i_value = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_read_value;

    transactional_memory_commit_engine_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct {
        t_status     status;
        logic [31:0] rd;
    } t_result;

    bit          mem_vld [MEM_DEPTH];
    logic [31:0] mem_val [MEM_DEPTH];
    logic [31:0] mem_ver [MEM_DEPTH];
    bit          rlog_vld [CONTEXTS][LOG_DEPTH];
    logic [7:0]  rlog_loc [CONTEXTS][LOG_DEPTH];
    logic [31:0] rlog_ver [CONTEXTS][LOG_DEPTH];
    bit          wbuf_vld [CONTEXTS][LOG_DEPTH];
    logic [7:0]  wbuf_loc [CONTEXTS][LOG_DEPTH];
    logic [31:0] wbuf_val [CONTEXTS][LOG_DEPTH];

    t_result pending_results[$];
    int      errors = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      quiet_cycles = 0;

    function automatic void drop_context(int c);
        for (int i = 0; i < LOG_DEPTH; i++) begin
            rlog_vld[c][i] = 0;
            wbuf_vld[c][i] = 0;
        end
    endfunction

    function automatic t_result predict_txn(t_kind k, int c, logic [7:0] loc, logic [31:0] v);
        t_result r;
        int      s;
        bit      ok;
        r.status = ST_OK;
        r.rd = '0;
        s = -1;
        ok = 1;
        case (k)
            K_INIT: begin
                if (!mem_vld[loc]) begin
                    mem_vld[loc] = 1;
                    mem_val[loc] = v;
                    mem_ver[loc] = '0;
                end
            end
            K_BEGIN: drop_context(c);
            K_FETCH: begin
                for (int i = LOG_DEPTH - 1; i >= 0; i--)
                    if (wbuf_vld[c][i] && wbuf_loc[c][i] == loc) s = i;
                if (s >= 0) begin
                    r.rd = wbuf_val[c][s];
                end else if (!mem_vld[loc]) begin
                    r.status = ST_UNINIT;
                end else begin
                    for (int i = LOG_DEPTH - 1; i >= 0; i--)
                        if (rlog_vld[c][i] && rlog_loc[c][i] == loc) s = i;
                    if (s < 0)
                        for (int i = LOG_DEPTH - 1; i >= 0; i--)
                            if (!rlog_vld[c][i]) s = i;
                    if (s < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        rlog_vld[c][s] = 1;
                        rlog_loc[c][s] = loc;
                        rlog_ver[c][s] = mem_ver[loc];
                        r.rd = mem_val[loc];
                    end
                end
            end
            K_STORE: begin
                for (int i = LOG_DEPTH - 1; i >= 0; i--)
                    if (wbuf_vld[c][i] && wbuf_loc[c][i] == loc) s = i;
                if (s < 0)
                    for (int i = LOG_DEPTH - 1; i >= 0; i--)
                        if (!wbuf_vld[c][i]) s = i;
                if (s < 0) begin
                    r.status = ST_FULL;
                end else begin
                    wbuf_vld[c][s] = 1;
                    wbuf_loc[c][s] = loc;
                    wbuf_val[c][s] = v;
                end
            end
            K_COMMIT: begin
                for (int i = 0; i < LOG_DEPTH; i++)
                    if (rlog_vld[c][i] && (!mem_vld[rlog_loc[c][i]] ||
                        mem_ver[rlog_loc[c][i]] != rlog_ver[c][i])) ok = 0;
                if (ok) begin
                    for (int i = 0; i < LOG_DEPTH; i++) begin
                        if (wbuf_vld[c][i]) begin
                            if (!mem_vld[wbuf_loc[c][i]]) begin
                                mem_vld[wbuf_loc[c][i]] = 1;
                                mem_ver[wbuf_loc[c][i]] = '0;
                            end else begin
                                mem_ver[wbuf_loc[c][i]] = mem_ver[wbuf_loc[c][i]] + 1;
                            end
                            mem_val[wbuf_loc[c][i]] = wbuf_val[c][i];
                        end
                    end
                end else begin
                    r.status = ST_CONFLICT;
                end
                drop_context(c);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_txn(logic [2:0] k, logic [1:0] c, logic [7:0] loc, logic [31:0] v);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= k;
        i_context_req <= c;
        i_location <= loc;
        i_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_txn(t_kind'(k), c, loc, v));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= (stall_pct > 0 && $urandom_range(99, 0) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d read_value %0d",
                         $time, o_status, o_read_value);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, o_status);
                    errors++;
                end
                if (o_read_value !== exp_r.rd) begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, $signed(exp_r.rd), o_read_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic logic [7:0] pick_loc();
        return ($urandom_range(3, 0) == 0) ? 8'($urandom) : 8'($urandom_range(15, 0));
    endfunction

    task automatic test_directed();
        send_txn(K_FETCH, 0, 8'd0, 0);
        send_txn(K_INIT, 0, 8'd0, 32'h8000_0000);
        send_txn(K_INIT, 1, 8'd255, 32'h7fff_ffff);
        send_txn(K_INIT, 2, 8'd0, 32'd5);
        send_txn(K_FETCH, 3, 8'd255, 0);
        send_txn(K_BEGIN, 0, 8'd0, 0);
        send_txn(K_FETCH, 0, 8'd0, 0);
        send_txn(K_FETCH, 0, 8'd0, 0);
        send_txn(K_STORE, 0, 8'd0, 32'hffff_ffff);
        send_txn(K_STORE, 0, 8'd0, 32'h1234_5678);
        send_txn(K_FETCH, 0, 8'd0, 0);
        send_txn(K_STORE, 1, 8'd255, 32'd9);
        send_txn(K_COMMIT, 1, 8'd0, 0);
        send_txn(K_FETCH, 2, 8'd255, 0);
        send_txn(K_COMMIT, 0, 8'd0, 0);
        send_txn(K_FETCH, 2, 8'd255, 0);
        send_txn(K_STORE, 3, 8'd255, 32'd1);
        send_txn(K_COMMIT, 2, 8'd0, 0);
        send_txn(K_COMMIT, 3, 8'd0, 0);
        send_txn(3'd5, 1, 8'hff, 32'hffff_ffff);
        send_txn(3'd7, 2, 8'd0, 0);
        send_txn(K_COMMIT, 3, 8'd77, 0);
    endtask

    task automatic test_log_full();
        send_txn(K_BEGIN, 1, 8'd0, 0);
        for (int i = 0; i < LOG_DEPTH + 1; i++) begin
            send_txn(K_INIT, 0, 8'(100 + i), i);
            send_txn(K_FETCH, 1, 8'(100 + i), 0);
        end
        for (int i = 0; i < LOG_DEPTH + 1; i++)
            send_txn(K_STORE, 1, 8'(200 + i), $urandom);
        send_txn(K_COMMIT, 1, 8'd0, 0);
    endtask

    task automatic test_random(int count);
        int c;
        for (int n = 0; n < count; n++) begin
            c = $urandom_range(3, 0);
            if ($urandom_range(9, 0) < 8) begin
                send_txn(K_BEGIN, 2'(c), 8'($urandom), $urandom);
                repeat ($urandom_range(LOG_DEPTH + 2, 1)) begin
                    send_txn($urandom_range(1, 0) ? K_FETCH : K_STORE, 2'(c),
                             pick_loc(), $urandom);
                    if ($urandom_range(4, 0) == 0)
                        send_txn(K_INIT, 2'($urandom), pick_loc(), $urandom);
                    if ($urandom_range(5, 0) == 0)
                        send_txn(K_COMMIT, 2'($urandom), pick_loc(), $urandom);
                end
                send_txn(K_COMMIT, 2'(c), 8'($urandom), $urandom);
                n += 4;
            end else begin
                send_txn(3'($urandom_range(7, 0)), 2'($urandom), pick_loc(), $urandom);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_log_full();
        test_random(72);
        idle_pct = 67;
        test_random(72);
        idle_pct = 0;
        stall_pct = 67;
        test_random(72);
        idle_pct = 17;
        stall_pct = 17;
        test_random(72);
        idle_pct = 0;
        stall_pct = 0;
        test_random(36);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("testbench: clean");
        else $display("testbench: errors");
        $finish;
    end
endmodule

`default_nettype wire
